[rtl/core/pps_pkg.sv]
// Shared widths, constants and bundle types of the priority scheduler.
package pps_pkg;

  localparam int unsigned PpsMaxProcs = 16;
  // Cell index width on the broadcast bus, wide enough for up to 64 cells.
  localparam int unsigned PpsIdxW     = 6;
  localparam int unsigned PpsArrW     = 16;
  localparam int unsigned PpsBurstW   = 8;
  localparam int unsigned PpsPrioW    = 8;
  localparam int unsigned PpsTimeW    = 17;
  localparam int unsigned PpsTaskIdxW = 4;

  // Task fields written into one cell.
  typedef struct packed {
    logic [PpsArrW-1:0]   arrival;
    logic [PpsBurstW-1:0] burst;
    logic [PpsPrioW-1:0]  prio;
  } pps_task_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic                wr;
    logic                clr;
    logic                dec;
    logic [PpsIdxW-1:0]  sel;
    logic [PpsTimeW-1:0] sim_clk;
  } pps_ctrl_t;

  // Partial selection result handed from cell to cell.
  typedef struct packed {
    logic                found;
    logic [PpsPrioW-1:0] best;
    logic [PpsIdxW-1:0]  pick;
    logic                any_future;
    logic [PpsArrW-1:0]  next_arr;
  } pps_wave_t;

  // Per-cell fields needed to build a result.
  typedef struct packed {
    logic [PpsArrW-1:0]   arrival;
    logic [PpsBurstW-1:0] burst;
    logic [PpsTimeW-1:0]  finish;
  } pps_view_t;

endpackage

[rtl/core/pps_in_if.sv]
// Task input channel: valid/ready handshake with the task fields.
interface pps_in_if import pps_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [PpsArrW-1:0]   arrival;
  logic [PpsBurstW-1:0] burst;
  logic [PpsPrioW-1:0]  priority_req;
  logic                 last_task;

  modport source (output valid, output arrival, output burst, output priority_req,
                  output last_task, input ready);
  modport sink   (input valid, input arrival, input burst, input priority_req,
                  input last_task, output ready);
endinterface

[rtl/core/pps_out_if.sv]
// Result output channel: valid/ready handshake with the per-task statistics.
interface pps_out_if import pps_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [PpsTaskIdxW-1:0] task_index;
  logic [PpsTimeW-1:0]    completion_time;
  logic [PpsTimeW-1:0]    turnaround;
  logic [PpsTimeW-1:0]    waiting;
  logic                   last_result;

  modport source (output valid, output task_index, output completion_time,
                  output turnaround, output waiting, output last_result, input ready);
  modport sink   (input valid, input task_index, input completion_time,
                  input turnaround, input waiting, input last_result, output ready);
endinterface

[rtl/core/pps_cell.sv]
// One scheduler cell: holds a task and folds it into the passing selection wave.
module pps_cell import pps_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [PpsIdxW-1:0] idx_i,
  input  pps_ctrl_t          ctrl_i,
  input  pps_task_t          task_i,
  input  pps_wave_t          wave_i,
  output pps_wave_t          wave_o,
  output pps_view_t          view_o
);

  logic                 loaded_q;
  logic [PpsArrW-1:0]   arrival_q;
  logic [PpsBurstW-1:0] burst_q;
  logic [PpsPrioW-1:0]  prio_q;
  logic [PpsBurstW-1:0] rem_q;
  logic [PpsTimeW-1:0]  fin_q;
  pps_wave_t            wave_q;
  pps_wave_t            wave_d;

  logic hit;
  logic active;
  logic arrived;

  assign hit     = (ctrl_i.sel == idx_i);
  assign active  = loaded_q && (rem_q != '0);
  assign arrived = ({1'b0, arrival_q} <= ctrl_i.sim_clk);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= 1'b0;
    end else if (ctrl_i.clr) begin
      loaded_q <= 1'b0;
    end else if (ctrl_i.wr && hit) begin
      loaded_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr && hit) begin
      arrival_q <= task_i.arrival;
      burst_q   <= task_i.burst;
      prio_q    <= task_i.prio;
      rem_q     <= task_i.burst;
    end else if (ctrl_i.dec && hit) begin
      rem_q <= rem_q - PpsBurstW'(1);
      // record the finish tick on the last tick of service
      if (rem_q == PpsBurstW'(1)) begin
        fin_q <= ctrl_i.sim_clk + PpsTimeW'(1);
      end
    end
  end

  always_comb begin
    wave_d = wave_i;
    if (active && arrived) begin
      if (!wave_i.found || (prio_q < wave_i.best)) begin
        wave_d.found = 1'b1;
        wave_d.best  = prio_q;
        wave_d.pick  = idx_i;
      end
    end else if (active) begin
      if (!wave_i.any_future || (arrival_q < wave_i.next_arr)) begin
        wave_d.any_future = 1'b1;
        wave_d.next_arr   = arrival_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wave_q <= wave_d;
  end

  assign wave_o         = wave_q;
  assign view_o.arrival = arrival_q;
  assign view_o.burst   = burst_q;
  assign view_o.finish  = fin_q;

endmodule

[rtl/core/preemptive_priority_scheduler_core.sv]
// Tasks load at one transaction per cycle while the block is loading.
// After the task marked last, each simulated tick (and each idle gap) takes
// one selection sweep down the cell chain, plus one final sweep.
// Results then leave at one transaction per cycle while the sink is ready; input is stalled until the last one.
// Reset clears the sequencer, the task count and every cell's loaded flag.
module preemptive_priority_scheduler_core import pps_pkg::*; #(
  parameter int unsigned MaxProcs = PpsMaxProcs
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pps_in_if.sink    task_i,
  pps_out_if.source result_o
);

  localparam int unsigned IdxW = (MaxProcs > 1) ? $clog2(MaxProcs) : 1;
  localparam int unsigned CntW = $clog2(MaxProcs + 1);

  localparam logic [1:0] StLoad  = 2'd0;
  localparam logic [1:0] StSweep = 2'd1;
  localparam logic [1:0] StEmit  = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [CntW-1:0]     sweep_q, sweep_d;
  logic [IdxW-1:0]     emit_q, emit_d;
  logic [PpsTimeW-1:0] sim_q, sim_d;
  logic                out_valid_q, out_valid_d;

  logic [PpsTaskIdxW-1:0] tidx_q;
  logic [PpsTimeW-1:0]    ct_q, tat_q, wt_q;
  logic                   lastr_q;

  pps_ctrl_t ctrl;
  pps_task_t wr_task;
  pps_wave_t wave [MaxProcs+1];
  pps_view_t views [MaxProcs];
  pps_wave_t tail;
  pps_view_t sel_view;

  logic                   in_ready;
  logic                   accept;
  logic                   out_load;
  logic                   emit_last;
  logic [IdxW+3:0]        emit_ext;
  logic [PpsTimeW-1:0]    tat;
  logic [PpsTimeW-1:0]    wt;

  assign wave[0] = '0;
  assign tail    = wave[MaxProcs];

  for (genvar k = 0; k < MaxProcs; k++) begin : g_cell
    pps_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (PpsIdxW'(k)),
      .ctrl_i (ctrl),
      .task_i (wr_task),
      .wave_i (wave[k]),
      .wave_o (wave[k+1]),
      .view_o (views[k])
    );
  end

  assign wr_task.arrival = task_i.arrival;
  assign wr_task.burst   = (task_i.burst == '0) ? PpsBurstW'(1) : task_i.burst;
  assign wr_task.prio    = task_i.priority_req;

  assign in_ready  = (state_q == StLoad);
  assign accept    = task_i.valid && in_ready;
  assign emit_last = ((CntW'(emit_q) + CntW'(1)) == count_q);
  assign out_load  = (state_q == StEmit) && (!out_valid_q || result_o.ready);

  assign sel_view = views[emit_q];
  assign tat      = sel_view.finish - {1'b0, sel_view.arrival};
  assign wt       = tat - PpsTimeW'(sel_view.burst);
  assign emit_ext = (IdxW + 4)'(emit_q);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    sweep_d      = sweep_q;
    emit_d       = emit_q;
    sim_d        = sim_q;
    ctrl         = '0;
    ctrl.sim_clk = sim_q;
    case (state_q)
      StLoad: begin
        if (accept) begin
          // drop tasks beyond the cell count, but still honor the last mark
          if (count_q < CntW'(MaxProcs)) begin
            ctrl.wr  = 1'b1;
            ctrl.sel = PpsIdxW'(count_q);
            count_d  = count_q + CntW'(1);
          end
          if (task_i.last_task) begin
            state_d = StSweep;
            sim_d   = '0;
            sweep_d = '0;
          end
        end
      end
      StSweep: begin
        if (sweep_q == CntW'(MaxProcs)) begin
          sweep_d = '0;
          if (tail.found) begin
            ctrl.dec = 1'b1;
            ctrl.sel = tail.pick;
            sim_d    = sim_q + PpsTimeW'(1);
          end else if (tail.any_future) begin
            // skip the idle gap up to the next arrival
            sim_d = PpsTimeW'(tail.next_arr);
          end else begin
            state_d = StEmit;
            emit_d  = '0;
          end
        end else begin
          sweep_d = sweep_q + CntW'(1);
        end
      end
      StEmit: begin
        if (out_load) begin
          emit_d = emit_q + IdxW'(1);
          if (emit_last) begin
            state_d  = StLoad;
            count_d  = '0;
            emit_d   = '0;
            ctrl.clr = 1'b1;
          end
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StLoad;
      count_q     <= '0;
      sweep_q     <= '0;
      emit_q      <= '0;
      sim_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      sweep_q     <= sweep_d;
      emit_q      <= emit_d;
      sim_q       <= sim_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      tidx_q  <= emit_ext[PpsTaskIdxW-1:0];
      ct_q    <= sel_view.finish;
      tat_q   <= tat;
      wt_q    <= wt;
      lastr_q <= emit_last;
    end
  end

  assign task_i.ready             = in_ready;
  assign result_o.valid           = out_valid_q;
  assign result_o.task_index      = tidx_q;
  assign result_o.completion_time = ct_q;
  assign result_o.turnaround      = tat_q;
  assign result_o.waiting         = wt_q;
  assign result_o.last_result     = lastr_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxProcs))
    else $error("task count exceeds cell count");

  a_sweep_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSweep) |-> (count_q != '0))
    else $error("simulation running with no loaded task");

  a_pick_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSweep && sweep_q == CntW'(MaxProcs) && tail.found)
      |-> (CntW'(tail.pick) < count_q))
    else $error("selected task lies beyond the loaded cells");

  a_run_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && emit_last)
      |=> (state_q == StLoad && count_q == '0 && result_o.valid && result_o.last_result))
    else $error("run did not close after the final result");

endmodule
